// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL files; the top-level module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/msi_pkg.sv =====
package msi_pkg;

    localparam int MAX_POINTS = 8;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int NP_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int DATA_W     = 32;
    localparam int HALF_W     = DATA_W / 2;
    localparam int FRAC_W     = 16;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;
    localparam int VIRT_MULT = 1000;

    // Shared multiplier: 34-bit signed by 17-bit signed half-word
    localparam int MUL_A_W = DATA_W + 2;
    localparam int MUL_B_W = HALF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 2 * DATA_W + 2;

    // Quotient of the interpolation never exceeds 33 bits
    localparam int DIV_STEPS = DATA_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_POINTS = 2'd0,
        REG_RESIDUAL   = 2'd1,
        REG_SCALE      = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR_LAST,
        S_ADDR_FIRST,
        S_VIRT,
        S_SEARCH,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_DIV_GO,
        S_DIV,
        S_FIN,
        S_SAT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [2*DATA_W-1:0]   dividend;
        logic [DATA_W-1:0]     divisor;
    } div_req_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if ((&top) || (~|top))
            return v[DATA_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

// ===== hw/rtl/msi_bpt.sv =====
// Breakpoint table: one write port, one read port, registered read data.
module msi_bpt
    import msi_pkg::*;
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [IDX_W-1:0]         waddr,
    input  logic signed [DATA_W-1:0] wdef,
    input  logic signed [DATA_W-1:0] wstf,
    input  logic [IDX_W-1:0]         raddr,
    output logic signed [DATA_W-1:0] rdef,
    output logic signed [DATA_W-1:0] rstf
);

    logic signed [DATA_W-1:0] def_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] stf_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] rdef_reg;
    logic signed [DATA_W-1:0] rstf_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            def_mem[waddr] <= wdef;
            stf_mem[waddr] <= wstf;
        end
        rdef_reg <= def_mem[raddr];
        rstf_reg <= stf_mem[raddr];
    end

    assign rdef = rdef_reg;
    assign rstf = rstf_reg;

endmodule

// ===== hw/rtl/msi_mul.sv =====
// Shared multiplier, product registered.
module msi_mul
    import msi_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/msi_div.sv =====
// Restoring divider, one quotient bit per cycle.
module msi_div
    import msi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output logic                 done,
    output logic [DIV_STEPS-1:0] quotient
);

    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_STEPS-1:0] bits_reg, bits_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DATA_W:0]      shifted;
    logic                 ge;

    always_comb
    begin
        shifted   = {rem_reg, bits_reg[DIV_STEPS-1]};
        ge        = (shifted >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // top bits of the dividend already sit below the divisor
            rem_next  = {{(DIV_STEPS-DATA_W){1'b0}}, req.dividend[2*DATA_W-1:DIV_STEPS]};
            bits_next = req.dividend[DIV_STEPS-1:0];
            dvs_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? DATA_W'(shifted - {1'b0, dvs_reg}) : shifted[DATA_W-1:0];
            bits_next = {bits_reg[DIV_STEPS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        bits_reg <= bits_next;
    end

    assign done     = done_reg;
    assign quotient = bits_reg;

endmodule

// ===== hw/rtl/multilinear_stiffness_interpolator_top.sv =====
// Piecewise-linear stiffness lookup over a breakpoint table (Q16.16 throughout).
// Input channel: drive cmd and its fields, raise start; the beat is taken on a rising
//   edge where start is high and busy is low. A load beat writes one table entry in
//   that edge and leaves busy low, so the next beat may follow right away.
// An evaluate beat raises busy until its result is out. A point on a breakpoint is
//   answered straight from the search; a point past the last breakpoint, or one that
//   no segment matches, goes through the final product only; a point inside a segment
//   goes through the interpolation product, the divider and then the final product.
//   busy drops with done, so the next beat may be taken while done is high.
//   The 33-step restoring divider sets the long case; the segment search
//   walks one breakpoint per cycle through the table's single read port; the products
//   share one multiplier, and all but the virtual point product take two half-word passes.
// Result channel: done is high for exactly one cycle with stiffness and
//   zero_width_segment valid; the receiver cannot stall it, so latch the beat then.
// Configuration: cfg_we writes cfg_data to the register cfg_index names; write only while idle.
//   Indexes beyond the register list are dropped.
// Reset: asynchronous, active low. Clear the sequencer, drop any pending result, and
//   restore num_points to 1 and both scale registers to 1.0. Table contents are kept
//   as they are and must be loaded before they are evaluated.
`include "assert_macros.svh"

module multilinear_stiffness_interpolator_top
    import msi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     cmd,
    input  logic [IDX_W-1:0]         point_index,
    input  logic signed [DATA_W-1:0] breakpoint_deformation,
    input  logic signed [DATA_W-1:0] breakpoint_stiffness,
    input  logic signed [DATA_W-1:0] deformation,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    output logic                     done,
    output logic signed [DATA_W-1:0] stiffness,
    output logic                     zero_width_segment
);

    state_t state_reg, state_next;

    // configuration
    logic [NP_W-1:0]          num_points_reg, num_points_next;
    logic signed [DATA_W-1:0] residual_reg, residual_next;
    logic signed [DATA_W-1:0] scale_reg, scale_next;

    // evaluation context
    logic signed [DATA_W-1:0] d_reg, d_next;
    logic [IDX_W-1:0]         last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]         seg_reg, seg_next;
    logic signed [DATA_W-1:0] last_def_reg, last_def_next;
    logic signed [DATA_W-1:0] last_stf_reg, last_stf_next;
    logic signed [DATA_W-1:0] virt_def_reg, virt_def_next;
    logic signed [DATA_W-1:0] stf0_reg, stf0_next;
    logic signed [DATA_W-1:0] x1_reg, x1_next;
    logic signed [DATA_W-1:0] y1_reg, y1_next;
    logic                     neg_reg, neg_next;
    logic [DATA_W-1:0]        dx_reg, dx_next;
    logic signed [DATA_W-1:0] k_reg, k_next;

    // shared multiplier operands and accumulator
    logic signed [MUL_A_W-1:0] mul_a_reg, mul_a_next;
    logic [DATA_W-1:0]         mul_b_reg, mul_b_next;
    logic                      mul_b_signed_reg, mul_b_signed_next;
    logic                      fin_reg, fin_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    // result beat
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] stiffness_reg, stiffness_next;
    logic                     zws_reg, zws_next;

    // table, multiplier and divider hookup
    logic                      tbl_we;
    logic [IDX_W-1:0]          raddr;
    logic signed [DATA_W-1:0]  rd_def;
    logic signed [DATA_W-1:0]  rd_stf;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_ext;
    div_req_t                  div_req;
    logic                      div_done;
    logic [DIV_STEPS-1:0]      quotient;

    // segment test
    logic                     last_seg;
    logic signed [DATA_W-1:0] x2;
    logic signed [DATA_W-1:0] y2;
    logic                     in_seg;
    logic                     on_point;
    logic signed [DATA_W:0]   dy;
    logic [DATA_W:0]          mag;
    logic signed [DATA_W+1:0] q_ext;
    logic signed [DATA_W+1:0] off;
    logic signed [DATA_W+1:0] ksum;
    logic signed [DATA_W-1:0] fin_a;
    logic signed [DATA_W-1:0] fin_b;

    assign busy   = (state_reg != S_IDLE);
    assign tbl_we = start && !busy && (cmd == CMD_LOAD);

    msi_bpt u_bpt (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (point_index),
        .wdef  (breakpoint_deformation),
        .wstf  (breakpoint_stiffness),
        .raddr (raddr),
        .rdef  (rd_def),
        .rstf  (rd_stf)
    );

    msi_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    msi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    assign div_req.start    = (state_reg == S_DIV_GO);
    assign div_req.dividend = acc_reg[2*DATA_W-1:0];
    assign div_req.divisor  = dx_reg;

    // Segment i runs from (x1, y1) to entry i+1, or to the virtual point past the end.
    always_comb
    begin
        last_seg = (seg_reg == last_idx_reg);
        x2       = last_seg ? virt_def_reg : rd_def;
        y2       = last_seg ? last_stf_reg : rd_stf;
        in_seg   = (d_reg >= x1_reg) && (d_reg < x2);
        on_point = (d_reg == x1_reg);
        dy       = {y2[DATA_W-1], y2} - {y1_reg[DATA_W-1], y1_reg};
        mag      = dy[DATA_W] ? (DATA_W+1)'(-dy) : (DATA_W+1)'(dy);
        q_ext    = {1'b0, quotient};
        off      = neg_reg ? -q_ext : q_ext;
        ksum     = {{2{y1_reg[DATA_W-1]}}, y1_reg} + off;
        // override scale replaces the residual product
        fin_a    = (scale_reg != Q_ONE) ? stf0_reg : residual_reg;
        fin_b    = (scale_reg != Q_ONE) ? scale_reg : k_reg;
    end

    // Table read address and multiplier operands
    always_comb
    begin
        raddr = '0;
        mul_a = mul_a_reg;
        mul_b = {1'b0, mul_b_reg[HALF_W-1:0]};
        case (state_reg)
            S_ADDR_LAST:
            begin
                raddr = last_idx_reg;
            end
            S_ADDR_FIRST:
            begin
                raddr = '0;
                // last deformation arrives: start the virtual point product
                mul_a = {{2{rd_def[DATA_W-1]}}, rd_def};
                mul_b = MUL_B_W'(VIRT_MULT);
            end
            S_VIRT:
            begin
                raddr = IDX_W'(1);
            end
            S_SEARCH:
            begin
                raddr = seg_reg + IDX_W'(2);
            end
            S_MUL_HI:
            begin
                mul_b = {mul_b_signed_reg & mul_b_reg[DATA_W-1], mul_b_reg[DATA_W-1:HALF_W]};
            end
            default:
            begin
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (cmd == CMD_EVAL))
                    state_next = S_ADDR_LAST;
            end
            S_ADDR_LAST:  state_next = S_ADDR_FIRST;
            S_ADDR_FIRST: state_next = S_VIRT;
            S_VIRT:
            begin
                state_next = (d_reg > last_def_reg) ? S_FIN : S_SEARCH;
            end
            S_SEARCH:
            begin
                if (in_seg)
                    state_next = (on_point || (x2 == x1_reg)) ? S_IDLE : S_MUL_LO;
                else if (last_seg)
                    state_next = S_FIN;
            end
            S_MUL_LO:  state_next = S_MUL_HI;
            S_MUL_HI:  state_next = S_MUL_SUM;
            S_MUL_SUM: state_next = fin_reg ? S_SAT : S_DIV_GO;
            S_DIV_GO:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_FIN;
            end
            S_FIN: state_next = S_MUL_LO;
            S_SAT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        num_points_next   = num_points_reg;
        residual_next     = residual_reg;
        scale_next        = scale_reg;
        d_next            = d_reg;
        last_idx_next     = last_idx_reg;
        seg_next          = seg_reg;
        last_def_next     = last_def_reg;
        last_stf_next     = last_stf_reg;
        virt_def_next     = virt_def_reg;
        stf0_next         = stf0_reg;
        x1_next           = x1_reg;
        y1_next           = y1_reg;
        neg_next          = neg_reg;
        dx_next           = dx_reg;
        k_next            = k_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        mul_b_signed_next = mul_b_signed_reg;
        fin_next          = fin_reg;
        acc_next          = acc_reg;
        done_next         = 1'b0;
        stiffness_next    = stiffness_reg;
        zws_next          = zws_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_POINTS: num_points_next = cfg_data[NP_W-1:0];
                REG_RESIDUAL:   residual_next   = cfg_data;
                REG_SCALE:      scale_next      = cfg_data;
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                d_next = deformation;
                // zero points acts as one, too many acts as a full table
                if (num_points_reg == '0)
                    last_idx_next = '0;
                else if (num_points_reg > NP_W'(MAX_POINTS))
                    last_idx_next = IDX_W'(MAX_POINTS - 1);
                else
                    last_idx_next = IDX_W'(num_points_reg - 1'b1);
            end
            S_ADDR_FIRST:
            begin
                last_def_next = rd_def;
                last_stf_next = rd_stf;
            end
            S_VIRT:
            begin
                virt_def_next = sat32(prod_ext);
                x1_next       = rd_def;
                y1_next       = rd_stf;
                stf0_next     = rd_stf;
                seg_next      = '0;
                k_next        = last_stf_reg;
            end
            S_SEARCH:
            begin
                if (in_seg)
                begin
                    if (on_point || (x2 == x1_reg))
                    begin
                        // on a breakpoint: return its stiffness unscaled
                        done_next      = 1'b1;
                        stiffness_next = on_point ? y1_reg : '0;
                        zws_next       = !on_point;
                    end
                    neg_next          = dy[DATA_W];
                    dx_next           = DATA_W'(x2 - x1_reg);
                    mul_a_next        = {1'b0, mag};
                    mul_b_next        = DATA_W'(d_reg - x1_reg);
                    mul_b_signed_next = 1'b0;
                    fin_next          = 1'b0;
                end
                else
                begin
                    // advance to the next segment
                    x1_next  = x2;
                    y1_next  = y2;
                    seg_next = seg_reg + 1'b1;
                    k_next   = '0;
                end
            end
            S_MUL_HI:
            begin
                acc_next = prod_ext;
            end
            S_MUL_SUM:
            begin
                acc_next = acc_reg + (prod_ext <<< HALF_W);
            end
            S_DIV:
            begin
                if (div_done)
                    k_next = ksum[DATA_W-1:0];
            end
            S_FIN:
            begin
                mul_a_next        = {{2{fin_a[DATA_W-1]}}, fin_a};
                mul_b_next        = fin_b;
                mul_b_signed_next = 1'b1;
                fin_next          = 1'b1;
            end
            S_SAT:
            begin
                done_next      = 1'b1;
                stiffness_next = sat32(acc_reg >>> FRAC_W);
                zws_next       = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_points_reg <= NP_W'(1);
            residual_reg   <= Q_ONE;
            scale_reg      <= Q_ONE;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_points_reg <= num_points_next;
            residual_reg   <= residual_next;
            scale_reg      <= scale_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg            <= d_next;
        last_idx_reg     <= last_idx_next;
        seg_reg          <= seg_next;
        last_def_reg     <= last_def_next;
        last_stf_reg     <= last_stf_next;
        virt_def_reg     <= virt_def_next;
        stf0_reg         <= stf0_next;
        x1_reg           <= x1_next;
        y1_reg           <= y1_next;
        neg_reg          <= neg_next;
        dx_reg           <= dx_next;
        k_reg            <= k_next;
        mul_a_reg        <= mul_a_next;
        mul_b_reg        <= mul_b_next;
        mul_b_signed_reg <= mul_b_signed_next;
        fin_reg          <= fin_next;
        acc_reg          <= acc_next;
        stiffness_reg    <= stiffness_next;
        zws_reg          <= zws_next;
    end

    assign done               = done_reg;
    assign stiffness          = stiffness_reg;
    assign zero_width_segment = zws_reg;

    `ASSERT_IMPL(a_done_after_work, done, $past(busy), "result beat without an evaluation")
    `ASSERT_IMPL(a_seg_in_range, state_reg == S_SEARCH, seg_reg <= last_idx_reg, "segment past table")
    `ASSERT_IMPL(a_div_in_wait, div_done, state_reg == S_DIV, "divider finished outside its wait")
    `ASSERT_IMPL(a_div_nonzero, state_reg == S_DIV_GO, dx_reg != '0, "division by a zero width")
    `ASSERT_NEXT(a_sat_delivers, state_reg == S_SAT, done && !busy, "scaled result not delivered")

endmodule
